// ===== hw/rtl/sirs_pkg.sv =====
// Shared types, constants and helpers for the spatial IRNN sweep block.
package sirs_pkg;

	localparam int DEF_CHANNELS  = 16;
	localparam int DEF_POSITIONS = 1024;
	localparam int DEF_SLICES    = 256;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic       OP_LOAD   = 1'b0;
	localparam logic       OP_SAMPLE = 1'b1;

	localparam logic       REG_FRACTION_BITS = 1'b0;
	localparam logic [3:0] FRACTION_BITS_RESET = 4'd8;

	typedef struct packed {
		logic               opcode;
		logic [3:0]         channel;
		logic [3:0]         weight_column;
		logic [9:0]         position;
		logic [7:0]         slice_index;
		logic signed [15:0] value;
	} sirs_item_t;

	typedef struct packed {
		logic [14:0] hidden_value;
		logic [3:0]  out_channel;
		logic [9:0]  out_position;
	} sirs_result_t;

	typedef struct packed {
		logic w_we;
		logic h_we;
		logic rd_en;
		logic acc_init;
	} sirs_ctl_t;

	function automatic int idx_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// ===== hw/rtl/sirs_mem.sv =====
// Weight memory and ping-pong hidden-value memory, with registered reads.
module sirs_mem #(
	parameter int CHANNELS  = sirs_pkg::DEF_CHANNELS,
	parameter int POSITIONS = sirs_pkg::DEF_POSITIONS
) (
	input  logic                                                   clk,
	input  sirs_pkg::sirs_ctl_t                                    ctl,
	input  logic [sirs_pkg::idx_w(CHANNELS*CHANNELS)-1:0]          w_addr,
	input  logic signed [15:0]                                     w_wdata,
	output logic signed [15:0]                                     w_rdata,
	input  logic [sirs_pkg::idx_w(2*CHANNELS*POSITIONS)-1:0]       h_rd_addr,
	input  logic [sirs_pkg::idx_w(2*CHANNELS*POSITIONS)-1:0]       h_wr_addr,
	input  logic [14:0]                                            h_wdata,
	output logic [14:0]                                            h_rdata
);
	import sirs_pkg::*;

	localparam int W_DEPTH = CHANNELS * CHANNELS;
	localparam int H_DEPTH = 2 * CHANNELS * POSITIONS;

	logic signed [15:0] wmem [W_DEPTH];
	logic [14:0]        hmem [H_DEPTH];
	logic signed [15:0] w_rdata_s1;
	logic [14:0]        h_rdata_s1;

	always_ff @(posedge clk) begin
		if (ctl.w_we) begin
			wmem[w_addr] <= w_wdata;
		end
		if (ctl.rd_en) begin
			w_rdata_s1 <= wmem[w_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.h_we) begin
			hmem[h_wr_addr] <= h_wdata;
		end
		if (ctl.rd_en) begin
			h_rdata_s1 <= hmem[h_rd_addr];
		end
	end

	assign w_rdata = w_rdata_s1;
	assign h_rdata = h_rdata_s1;

endmodule

// ===== hw/rtl/sirs_mac.sv =====
// Shared multiply-accumulate with product shift, saturation and ReLU.
module sirs_mac #(
	parameter int CHANNELS = sirs_pkg::DEF_CHANNELS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sirs_pkg::sirs_ctl_t ctl,
	input  logic [3:0]          fraction_bits,
	input  logic signed [15:0]  init_value,
	input  logic signed [15:0]  w_rdata,
	input  logic [14:0]         h_rdata,
	output logic                busy,
	output logic [14:0]         result
);
	import sirs_pkg::*;

	localparam int ACC_W = 33 + idx_w(CHANNELS);

	logic                    valid_s1;
	logic                    valid_s2;
	logic signed [31:0]      prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic                    acc_neg;
	logic                    acc_over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl.rd_en;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2 <= w_rdata * $signed({1'b0, h_rdata});
		end
		if (ctl.acc_init) begin
			acc_q <= ACC_W'(init_value);
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2 >>> fraction_bits);
		end
	end

	assign busy     = valid_s1 | valid_s2;
	assign acc_neg  = acc_q[ACC_W-1];
	assign acc_over = |acc_q[ACC_W-2:15];

	always_comb begin
		if (acc_neg) begin
			result = '0;
		end else if (acc_over) begin
			result = '1;
		end else begin
			result = acc_q[14:0];
		end
	end

endmodule

// ===== hw/rtl/sirs_seq.sv =====
// Item sequencer: range checks, address generation and the column walk.
module sirs_seq #(
	parameter int CHANNELS  = sirs_pkg::DEF_CHANNELS,
	parameter int POSITIONS = sirs_pkg::DEF_POSITIONS,
	parameter int SLICES    = sirs_pkg::DEF_SLICES
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             item_valid,
	input  sirs_pkg::sirs_item_t                             item,
	output logic                                             item_ready,
	input  logic                                             out_free,
	input  logic                                             mac_busy,
	output sirs_pkg::sirs_ctl_t                              ctl,
	output logic [sirs_pkg::idx_w(CHANNELS*CHANNELS)-1:0]    w_addr,
	output logic [sirs_pkg::idx_w(2*CHANNELS*POSITIONS)-1:0] h_rd_addr,
	output logic [sirs_pkg::idx_w(2*CHANNELS*POSITIONS)-1:0] h_wr_addr,
	output logic signed [15:0]                               w_wdata,
	output logic signed [15:0]                               init_value,
	output logic                                             out_load,
	output logic [3:0]                                       out_channel,
	output logic [9:0]                                       out_position
);
	import sirs_pkg::*;

	localparam int CH_W = idx_w(CHANNELS);
	localparam int WA_W = idx_w(CHANNELS * CHANNELS);
	localparam int HA_W = idx_w(2 * CHANNELS * POSITIONS);

	localparam logic [HA_W-1:0] BANK_SPAN = HA_W'(CHANNELS * POSITIONS);
	localparam logic [HA_W-1:0] POS_STEP  = HA_W'(POSITIONS);
	localparam logic [WA_W-1:0] ROW_STEP  = WA_W'(CHANNELS);
	localparam logic [CH_W-1:0] K_LAST    = CH_W'(CHANNELS - 1);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_READ     = 3'd2;
	localparam logic [2:0] ST_DRAIN    = 3'd3;
	localparam logic [2:0] ST_FINISH   = 3'd4;

	logic [2:0]      state_q;
	logic [2:0]      state_d;
	logic [CH_W-1:0] k_q;
	sirs_item_t      req_q;
	logic            ok_q;
	logic [WA_W-1:0] w_addr_q;
	logic [HA_W-1:0] h_rd_addr_q;
	logic [HA_W-1:0] h_wr_addr_q;

	logic            ch_ok;
	logic            load_ok;
	logic            sample_ok;
	logic [WA_W-1:0] w_base;
	logic [HA_W-1:0] h_rd_base;
	logic [HA_W-1:0] h_wr_base;
	logic            is_load;

	assign ch_ok     = 32'(item.channel) < 32'(CHANNELS);
	assign load_ok   = ch_ok && (32'(item.weight_column) < 32'(CHANNELS));
	assign sample_ok = ch_ok && (32'(item.position) < 32'(POSITIONS))
		&& (32'(item.slice_index) < 32'(SLICES));

	assign w_base = WA_W'(item.channel) * ROW_STEP
		+ ((item.opcode == OP_LOAD) ? WA_W'(item.weight_column) : '0);
	assign h_rd_base = (item.slice_index[0] ? '0 : BANK_SPAN) + HA_W'(item.position);
	assign h_wr_base = (item.slice_index[0] ? BANK_SPAN : '0)
		+ HA_W'(item.channel) * POS_STEP + HA_W'(item.position);

	assign is_load = (req_q.opcode == OP_LOAD);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (!ok_q || is_load) begin
					state_d = ST_IDLE;
				end else if (req_q.slice_index == '0) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (k_q == K_LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!mac_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DISPATCH) begin
				k_q <= '0;
			end else if (state_q == ST_READ) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			req_q       <= item;
			ok_q        <= (item.opcode == OP_LOAD) ? load_ok : sample_ok;
			w_addr_q    <= w_base;
			h_rd_addr_q <= h_rd_base;
			h_wr_addr_q <= h_wr_base;
		end else if (state_q == ST_READ) begin
			w_addr_q    <= w_addr_q + 1'b1;
			h_rd_addr_q <= h_rd_addr_q + POS_STEP;
		end
	end

	always_comb begin
		ctl          = '0;
		ctl.w_we     = (state_q == ST_DISPATCH) && ok_q && is_load;
		ctl.acc_init = (state_q == ST_DISPATCH) && ok_q && !is_load;
		ctl.rd_en    = (state_q == ST_READ);
		ctl.h_we     = (state_q == ST_FINISH) && out_free;
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign out_load     = ctl.h_we;
	assign w_addr       = w_addr_q;
	assign h_rd_addr    = h_rd_addr_q;
	assign h_wr_addr    = h_wr_addr_q;
	assign w_wdata      = req_q.value;
	assign init_value   = req_q.value;
	assign out_channel  = req_q.channel;
	assign out_position = req_q.position;

endmodule

// ===== hw/rtl/spatial_irnn_sweep.sv =====
// Top level of the spatial IRNN forward sweep with its register port.
//
// Items arrive on item_valid/item_ready/item; results leave on
// result_valid/result_ready/result. A transfer happens when valid and
// ready are both high at a rising edge of clk.
// A load item writes one weight entry and gives no result.
// A sample with slice 0 skips the walk; for a later slice, one
// multiply-accumulate walks the CHANNELS weight/hidden pairs, one memory
// read per cycle, then a two stage drain and a write-back of the new
// hidden value.
// Items out of range are dropped with no result.
// One item is worked on at a time; result sits in an output register, so
// the next item is taken while the last result waits for the receiver. A
// stalled receiver holds a finished item in its write-back step until the
// output register frees.
// fraction_bits lies at byte address 0 of the APB port; write it only
// while the block is idle.
// Reset clears control state and sets fraction_bits to 8; the weight and
// hidden memories hold nothing valid until written, no clearing pass.
module spatial_irnn_sweep #(
	parameter int CHANNELS  = sirs_pkg::DEF_CHANNELS,
	parameter int POSITIONS = sirs_pkg::DEF_POSITIONS,
	parameter int SLICES    = sirs_pkg::DEF_SLICES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  sirs_pkg::sirs_item_t           item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output sirs_pkg::sirs_result_t         result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sirs_pkg::PADDR_W-1:0]   paddr,
	input  logic [sirs_pkg::PDATA_W-1:0]   pwdata,
	output logic [sirs_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import sirs_pkg::*;

	localparam int WA_W = idx_w(CHANNELS * CHANNELS);
	localparam int HA_W = idx_w(2 * CHANNELS * POSITIONS);

	logic [3:0]         fraction_bits_q;
	logic               reg_sel;
	logic               out_free;
	logic               out_load;
	logic               mac_busy;
	sirs_ctl_t          ctl;
	logic [WA_W-1:0]    w_addr;
	logic [HA_W-1:0]    h_rd_addr;
	logic [HA_W-1:0]    h_wr_addr;
	logic signed [15:0] w_wdata;
	logic signed [15:0] init_value;
	logic signed [15:0] w_rdata;
	logic [14:0]        h_rdata;
	logic [14:0]        mac_result;
	logic [3:0]         out_channel;
	logic [9:0]         out_position;
	logic               result_valid_q;
	sirs_result_t       result_q;

	assign reg_sel = (paddr[2] == REG_FRACTION_BITS);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? PDATA_W'(fraction_bits_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fraction_bits_q <= FRACTION_BITS_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			fraction_bits_q <= pwdata[3:0];
		end
	end

	sirs_seq #(
		.CHANNELS  (CHANNELS),
		.POSITIONS (POSITIONS),
		.SLICES    (SLICES)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item         (item),
		.item_ready   (item_ready),
		.out_free     (out_free),
		.mac_busy     (mac_busy),
		.ctl          (ctl),
		.w_addr       (w_addr),
		.h_rd_addr    (h_rd_addr),
		.h_wr_addr    (h_wr_addr),
		.w_wdata      (w_wdata),
		.init_value   (init_value),
		.out_load     (out_load),
		.out_channel  (out_channel),
		.out_position (out_position)
	);

	sirs_mem #(
		.CHANNELS  (CHANNELS),
		.POSITIONS (POSITIONS)
	) u_mem (
		.clk       (clk),
		.ctl       (ctl),
		.w_addr    (w_addr),
		.w_wdata   (w_wdata),
		.w_rdata   (w_rdata),
		.h_rd_addr (h_rd_addr),
		.h_wr_addr (h_wr_addr),
		.h_wdata   (mac_result),
		.h_rdata   (h_rdata)
	);

	sirs_mac #(
		.CHANNELS (CHANNELS)
	) u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.fraction_bits (fraction_bits_q),
		.init_value    (init_value),
		.w_rdata       (w_rdata),
		.h_rdata       (h_rdata),
		.busy          (mac_busy),
		.result        (mac_result)
	);

	assign out_free = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.hidden_value <= mac_result;
			result_q.out_channel  <= out_channel;
			result_q.out_position <= out_position;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== hw/rtl/sirs_checker.sv =====
// Port-level checks for the spatial IRNN sweep, bound to the top level.
module sirs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input logic                         result_valid,
	input logic                         result_ready,
	input sirs_pkg::sirs_result_t       result,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [sirs_pkg::PADDR_W-1:0] paddr,
	input logic [sirs_pkg::PDATA_W-1:0] pwdata,
	input logic [sirs_pkg::PDATA_W-1:0] prdata,
	input logic                         pready
);
	import sirs_pkg::*;

	a_reset_no_result: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result valid during reset");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while previous one still in work");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result appeared with no item in work");

	a_reg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[2] == REG_FRACTION_BITS)
		##1 (psel && penable && !pwrite && paddr[2] == REG_FRACTION_BITS)
		|-> prdata[3:0] == $past(pwdata[3:0]))
		else $error("fraction_bits readback mismatch");

endmodule

bind spatial_irnn_sweep sirs_checker u_sirs_checker (.*);
